### sv/slerp_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion slerp package
// Widths, pipeline stage numbers, item kinds and the arctangent table that
// the slerp pipeline and its cells share.
// ----------------------------------------------------------------------------
package slerp_pkg;

  localparam int FRAC_BITS       = 14;
  localparam int TRIG_ITERATIONS = 16;
  localparam int ANG_BITS        = 30;
  localparam int TAB_LEN         = 31;

  localparam int COMP_W = 16;                  // quaternion component
  localparam int B_W    = COMP_W + 1;          // end component after negation
  localparam int T_W    = 15;                  // blend fraction
  localparam int THR_W  = 15;                  // near-one threshold
  localparam int ONE    = 1 << FRAC_BITS;

  localparam int C_W      = FRAC_BITS;         // dot product on the spherical path
  localparam int S_W      = FRAC_BITS + 1;     // sqrt(1 - c^2)
  localparam int RAD_W    = 2 * FRAC_BITS + 1; // radicand
  localparam int SQRT_STEPS = FRAC_BITS + 1;
  localparam int KW       = $clog2(SQRT_STEPS);
  localparam int SH_W     = $clog2(TAB_LEN);
  localparam int CW       = ANG_BITS + 4;      // CORDIC datapath
  localparam int UP       = ANG_BITS - FRAC_BITS;
  localparam int DQ_W     = CW + FRAC_BITS;    // dividend / quotient
  localparam int DIV_STEPS = DQ_W;
  localparam int PROD_W   = COMP_W + B_W;
  localparam int SUM_W    = PROD_W + 2;
  localparam int CF_W     = SUM_W - FRAC_BITS;
  localparam int AP_W     = CW + T_W + 1;
  localparam int MUL_W    = CW + B_W;
  localparam int ACC_W    = MUL_W + 1;
  localparam int RES_W    = ACC_W - ANG_BITS;

  localparam logic [THR_W-1:0]     THR_RESET = THR_W'(16383);
  localparam logic signed [CW-1:0] KINV      = CW'(652032874);

  // Pipeline stage numbers (register index of each step).
  localparam int ST_SUM   = 2;
  localparam int ST_RAD   = 3;
  localparam int ST_SQRT0 = ST_RAD + 1;
  localparam int ST_VEC0  = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_ANG   = ST_VEC0 + TRIG_ITERATIONS;
  localparam int ST_ROT0  = ST_ANG + 1;
  localparam int ST_DIV0  = ST_ROT0 + TRIG_ITERATIONS;
  localparam int ST_W     = ST_DIV0 + DIV_STEPS;
  localparam int ST_P     = ST_W + 1;
  localparam int ST_OUT   = ST_P + 1;
  localparam int NSTAGE   = ST_OUT + 1;

  typedef enum logic [1:0] {
    KIND_SLERP,
    KIND_LINEAR,
    KIND_START,
    KIND_END
  } kind_e;

  typedef struct packed {
    logic                        valid;
    kind_e                       kind;
    logic [3:0][COMP_W-1:0]      a;
    logic [3:0][B_W-1:0]         b;
    logic [T_W-1:0]              t;
    logic [C_W-1:0]              c;
    logic [S_W-1:0]              s;
    logic [1:0]                  neg;
  } side_t;

  // atan(2^-i) in Q2.30 radians.
  function automatic logic signed [CW-1:0] atan_q30(input logic [SH_W-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:  v = CW'(843314856);
      5'd1:  v = CW'(497837829);
      5'd2:  v = CW'(263043836);
      5'd3:  v = CW'(133525158);
      5'd4:  v = CW'(67021686);
      5'd5:  v = CW'(33543515);
      5'd6:  v = CW'(16775850);
      5'd7:  v = CW'(8388437);
      5'd8:  v = CW'(4194282);
      5'd9:  v = CW'(2097149);
      5'd10: v = CW'(1048575);
      5'd11: v = CW'(524287);
      5'd12: v = CW'(262143);
      5'd13: v = CW'(131071);
      5'd14: v = CW'(65535);
      5'd15: v = CW'(32767);
      5'd16: v = CW'(16383);
      5'd17: v = CW'(8191);
      5'd18: v = CW'(4095);
      5'd19: v = CW'(2047);
      5'd20: v = CW'(1023);
      5'd21: v = CW'(511);
      5'd22: v = CW'(255);
      5'd23: v = CW'(127);
      5'd24: v = CW'(63);
      5'd25: v = CW'(31);
      5'd26: v = CW'(15);
      5'd27: v = CW'(8);
      5'd28: v = CW'(4);
      5'd29: v = CW'(2);
      5'd30: v = CW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/slerp_if.sv
// ----------------------------------------------------------------------------
// Quaternion slerp channels
// Valid/ready channels for items, results and the threshold register.
// ----------------------------------------------------------------------------
interface slerp_in_if import slerp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] start_i;
  logic [COMP_W-1:0] start_j;
  logic [COMP_W-1:0] start_k;
  logic [COMP_W-1:0] start_r;
  logic [COMP_W-1:0] end_i;
  logic [COMP_W-1:0] end_j;
  logic [COMP_W-1:0] end_k;
  logic [COMP_W-1:0] end_r;
  logic [T_W-1:0]    blend_t;

  modport source (output valid, start_i, start_j, start_k, start_r,
                  end_i, end_j, end_k, end_r, blend_t, input ready);
  modport sink   (input valid, start_i, start_j, start_k, start_r,
                  end_i, end_j, end_k, end_r, blend_t, output ready);
endinterface

interface slerp_out_if import slerp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COMP_W-1:0] out_i;
  logic [COMP_W-1:0] out_j;
  logic [COMP_W-1:0] out_k;
  logic [COMP_W-1:0] out_r;

  modport source (output valid, out_i, out_j, out_k, out_r, input ready);
  modport sink   (input valid, out_i, out_j, out_k, out_r, output ready);
endinterface

interface slerp_cfg_if import slerp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] near_threshold;

  modport source (output valid, near_threshold, input ready);
  modport sink   (input valid, near_threshold, output ready);
endinterface

### sv/slerp_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Slerp square root cell
// One result bit of a digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module slerp_sqrt_cell import slerp_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [KW-1:0]    k_i,
  input  logic [RAD_W-1:0] rad_i,
  input  logic [RAD_W-1:0] root_i,
  output logic [RAD_W-1:0] rad_o,
  output logic [RAD_W-1:0] root_o
);

  logic [RAD_W-1:0] bit_w;
  logic [RAD_W:0]   trial;
  logic [RAD_W-1:0] rad_d, rad_q;
  logic [RAD_W-1:0] root_d, root_q;

  always_comb begin
    bit_w = RAD_W'(1) << {k_i, 1'b0};
    trial = {1'b0, root_i} + {1'b0, bit_w};
    if ({1'b0, rad_i} >= trial) begin
      rad_d  = rad_i - trial[RAD_W-1:0];
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rad_d  = rad_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      root_q <= root_d;
    end
  end

  assign rad_o  = rad_q;
  assign root_o = root_q;

endmodule

### sv/slerp_cordic_cell.sv
// ----------------------------------------------------------------------------
// Slerp CORDIC cell
// One micro-rotation, in vectoring or rotation mode, registered.
// ----------------------------------------------------------------------------
module slerp_cordic_cell import slerp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic                 vec_i,
  input  logic [SH_W-1:0]      shift_i,
  input  logic signed [CW-1:0] atan_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o
);

  logic                 ccw;
  logic signed [CW-1:0] dx, dy;
  logic signed [CW-1:0] x_d, y_d, z_d;
  logic signed [CW-1:0] x_q, y_q, z_q;

  always_comb begin
    dx = y_i >>> shift_i;
    dy = x_i >>> shift_i;
    // Vectoring drives y toward zero; rotation drives z toward zero.
    ccw = vec_i ? y_i[CW-1] : !z_i[CW-1];
    if (ccw) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan_i;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

### sv/slerp_div_cell.sv
// ----------------------------------------------------------------------------
// Slerp divider cell
// One quotient bit of a restoring division, registered.
// ----------------------------------------------------------------------------
module slerp_div_cell import slerp_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [S_W-1:0]  den_i,
  input  logic [S_W-1:0]  rem_i,
  input  logic [DQ_W-1:0] dq_i,
  output logic [S_W-1:0]  rem_o,
  output logic [DQ_W-1:0] dq_o
);

  logic [S_W:0]    part;
  logic [S_W:0]    diff;
  logic            ge;
  logic [S_W-1:0]  rem_d, rem_q;
  logic [DQ_W-1:0] dq_d, dq_q;

  always_comb begin
    part  = {rem_i, dq_i[DQ_W-1]};
    diff  = part - {1'b0, den_i};
    ge    = part >= {1'b0, den_i};
    rem_d = ge ? diff[S_W-1:0] : part[S_W-1:0];
    // Dividend bits shift out at the top while quotient bits shift in below.
    dq_d  = {dq_i[DQ_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      dq_q  <= dq_d;
    end
  end

  assign rem_o = rem_q;
  assign dq_o  = dq_q;

endmodule

### sv/quaternion_slerp.sv
// ----------------------------------------------------------------------------
// Quaternion slerp
// Fully pipelined spherical linear interpolation of two Q2.14 quaternions.
// ----------------------------------------------------------------------------
// Items arrive on req_i (start and end quaternion plus blend fraction t) and
// results leave on rsp_o (the blended quaternion, saturated to Q2.14). Both
// are valid/ready channels; a transfer happens when valid and ready are high.
// cfg_i writes the near-one threshold; it is always ready and should only be
// written while no item is in flight.
// The datapath is a row of registered cells: dot product, a square-root
// chain of 15 cells, a vectoring CORDIC chain of 16 cells, two rotation
// CORDIC chains of 16 cells and two divider chains of 48 cells, followed by
// the weighting multipliers and the output register. One item is taken every
// cycle while the output is not stalled. When the receiver holds ready low
// with a result waiting, the whole row freezes and req_i.ready drops; slots
// that hold bubbles are not squeezed.
// Reset clears every stage valid bit and loads the threshold with 16383.
// ----------------------------------------------------------------------------
module quaternion_slerp import slerp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  slerp_in_if.sink     req_i,
  slerp_out_if.source  rsp_o,
  slerp_cfg_if.sink    cfg_i
);

  logic             adv;
  logic [THR_W-1:0] thr_q;
  side_t            side_d [NSTAGE];
  side_t            side_q [NSTAGE];
  kind_e            kind0;

  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [SUM_W-1:0]  raw;
  logic                     dot_neg;
  logic [SUM_W-1:0]         mag;
  logic [CF_W-1:0]          c_full;
  logic                     lin;
  logic [RAD_W-1:0]         rad_q;

  logic [RAD_W-1:0]     rad_w  [SQRT_STEPS+1];
  logic [RAD_W-1:0]     root_w [SQRT_STEPS+1];
  logic signed [CW-1:0] vx [TRIG_ITERATIONS+1];
  logic signed [CW-1:0] vy [TRIG_ITERATIONS+1];
  logic signed [CW-1:0] vz [TRIG_ITERATIONS+1];

  logic [T_W-1:0]       wt   [2];
  logic signed [AP_W-1:0] ang_prod [2];
  logic signed [CW-1:0] ang_q [2];
  logic signed [CW-1:0] rx [2][TRIG_ITERATIONS+1];
  logic signed [CW-1:0] ry [2][TRIG_ITERATIONS+1];
  logic signed [CW-1:0] rz [2][TRIG_ITERATIONS+1];

  logic                 rneg [2];
  logic [CW-1:0]        rmag [2];
  logic [S_W-1:0]       rem_w [2][DIV_STEPS+1];
  logic [DQ_W-1:0]      dq_w  [2][DIV_STEPS+1];

  logic signed [CW-1:0]    w_d [2];
  logic signed [CW-1:0]    w_q [2];
  logic signed [MUL_W-1:0] pa_q [4];
  logic signed [MUL_W-1:0] pb_q [4];
  logic signed [ACC_W-1:0] acc [4];
  logic signed [RES_W-1:0] res [4];
  logic [COMP_W-1:0]       out_d [4];
  logic [COMP_W-1:0]       out_q [4];

  // The row moves whenever the output register is free or being emptied.
  assign adv         = !side_q[ST_OUT].valid || rsp_o.ready;
  assign req_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.near_threshold;
    end
  end

  // --------------------------------------------------------------------------
  // Front end: classify, dot product, radicand
  // --------------------------------------------------------------------------
  always_comb begin
    if (req_i.blend_t >= T_W'(ONE)) begin
      kind0 = KIND_END;
    end else if (req_i.blend_t == '0) begin
      kind0 = KIND_START;
    end else begin
      kind0 = KIND_SLERP;
    end
  end

  always_comb begin
    raw = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    dot_neg = raw[SUM_W-1];
    mag     = dot_neg ? SUM_W'(-raw) : SUM_W'(raw);
    c_full  = mag[SUM_W-1:FRAC_BITS];
    lin     = (c_full > CF_W'(thr_q)) || (c_full >= CF_W'(ONE));
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int n = 0; n < 4; n++) begin
        prod_q[n] <= $signed(side_q[0].a[n]) * $signed(side_q[0].b[n]);
      end
      rad_q <= (RAD_W'(1) << (2 * FRAC_BITS)) -
               (RAD_W'(side_q[ST_SUM].c) * RAD_W'(side_q[ST_SUM].c));
    end
  end

  // --------------------------------------------------------------------------
  // sqrt(1 - c^2)
  // --------------------------------------------------------------------------
  assign rad_w[0]  = rad_q;
  assign root_w[0] = '0;

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    slerp_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (adv),
      .k_i    (KW'(SQRT_STEPS - 1 - j)),
      .rad_i  (rad_w[j]),
      .root_i (root_w[j]),
      .rad_o  (rad_w[j+1]),
      .root_o (root_w[j+1])
    );
  end

  // --------------------------------------------------------------------------
  // theta = atan2(s, c)
  // --------------------------------------------------------------------------
  assign vx[0] = CW'(side_q[ST_VEC0-1].c) <<< UP;
  assign vy[0] = CW'(root_w[SQRT_STEPS][S_W-1:0]) <<< UP;
  assign vz[0] = '0;

  for (genvar j = 0; j < TRIG_ITERATIONS; j++) begin : g_vec
    slerp_cordic_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .vec_i   (1'b1),
      .shift_i (SH_W'(j)),
      .atan_i  (atan_q30(SH_W'(j))),
      .x_i     (vx[j]),
      .y_i     (vy[j]),
      .z_i     (vz[j]),
      .x_o     (vx[j+1]),
      .y_o     (vy[j+1]),
      .z_o     (vz[j+1])
    );
  end

  // Partial angles (1 - t) * theta and t * theta.
  assign wt[0] = T_W'(ONE) - side_q[ST_ANG-1].t;
  assign wt[1] = side_q[ST_ANG-1].t;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    assign ang_prod[l] = $signed({1'b0, wt[l]}) * vz[TRIG_ITERATIONS];

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ang_q[l] <= CW'(ang_prod[l] >>> FRAC_BITS);
      end
    end

    assign rx[l][0] = KINV;
    assign ry[l][0] = '0;
    assign rz[l][0] = ang_q[l];

    for (genvar j = 0; j < TRIG_ITERATIONS; j++) begin : g_rot
      slerp_cordic_cell u_cell (
        .clk_i   (clk_i),
        .en_i    (adv),
        .vec_i   (1'b0),
        .shift_i (SH_W'(j)),
        .atan_i  (atan_q30(SH_W'(j))),
        .x_i     (rx[l][j]),
        .y_i     (ry[l][j]),
        .z_i     (rz[l][j]),
        .x_o     (rx[l][j+1]),
        .y_o     (ry[l][j+1]),
        .z_o     (rz[l][j+1])
      );
    end

    // Divide |sin| << FRAC_BITS by s; the sign is restored afterwards.
    assign rneg[l] = ry[l][TRIG_ITERATIONS][CW-1];
    assign rmag[l] = rneg[l] ? CW'(-ry[l][TRIG_ITERATIONS]) : CW'(ry[l][TRIG_ITERATIONS]);
    assign rem_w[l][0] = '0;
    assign dq_w[l][0]  = DQ_W'(rmag[l]) << FRAC_BITS;

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      slerp_div_cell u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .den_i (side_q[ST_DIV0+j-1].s),
        .rem_i (rem_w[l][j]),
        .dq_i  (dq_w[l][j]),
        .rem_o (rem_w[l][j+1]),
        .dq_o  (dq_w[l][j+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // Weights, products, rounding and saturation
  // --------------------------------------------------------------------------
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (side_q[ST_W-1].neg[l]) begin
        w_d[l] = CW'(-$signed(dq_w[l][DIV_STEPS]));
      end else begin
        w_d[l] = CW'(dq_w[l][DIV_STEPS]);
      end
    end
    if (side_q[ST_W-1].kind == KIND_LINEAR) begin
      w_d[0] = CW'(T_W'(ONE) - side_q[ST_W-1].t) <<< UP;
      w_d[1] = CW'(side_q[ST_W-1].t) <<< UP;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q <= w_d;
      for (int n = 0; n < 4; n++) begin
        pa_q[n] <= w_q[0] * $signed(side_q[ST_P-1].a[n]);
        pb_q[n] <= w_q[1] * $signed(side_q[ST_P-1].b[n]);
      end
      out_q <= out_d;
    end
  end

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      acc[n] = ACC_W'(pa_q[n]) + ACC_W'(pb_q[n]) + (ACC_W'(1) <<< (ANG_BITS - 1));
      res[n] = RES_W'(acc[n] >>> ANG_BITS);
      if (res[n] > RES_W'(32767)) begin
        out_d[n] = 16'h7FFF;
      end else if (res[n] < -RES_W'(32768)) begin
        out_d[n] = 16'h8000;
      end else begin
        out_d[n] = res[n][COMP_W-1:0];
      end
      case (side_q[ST_OUT-1].kind)
        KIND_START: out_d[n] = side_q[ST_OUT-1].a[n];
        KIND_END:   out_d[n] = side_q[ST_OUT-1].b[n][COMP_W-1:0];
        default:    ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sideband row: item data and control that travel with each slot
  // --------------------------------------------------------------------------
  always_comb begin
    side_d[0].valid = req_i.valid;
    side_d[0].kind  = kind0;
    side_d[0].a     = {req_i.start_r, req_i.start_k, req_i.start_j, req_i.start_i};
    side_d[0].b     = {B_W'($signed(req_i.end_r)), B_W'($signed(req_i.end_k)),
                       B_W'($signed(req_i.end_j)), B_W'($signed(req_i.end_i))};
    side_d[0].t     = req_i.blend_t;
    side_d[0].c     = '0;
    side_d[0].s     = '0;
    side_d[0].neg   = '0;
    for (int k = 1; k < NSTAGE; k++) begin
      side_d[k] = side_q[k-1];
    end
    // A negative dot product flips the end quaternion onto the short arc.
    side_d[ST_SUM].c = c_full[C_W-1:0];
    if (side_q[ST_SUM-1].kind == KIND_SLERP) begin
      side_d[ST_SUM].kind = lin ? KIND_LINEAR : KIND_SLERP;
      if (dot_neg) begin
        for (int n = 0; n < 4; n++) begin
          side_d[ST_SUM].b[n] = B_W'(-$signed(side_q[ST_SUM-1].b[n]));
        end
      end
    end
    side_d[ST_VEC0].s   = root_w[SQRT_STEPS][S_W-1:0];
    side_d[ST_DIV0].neg = {rneg[1], rneg[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTAGE; k++) begin
        side_q[k].valid <= 1'b0;
      end
    end else if (adv) begin
      side_q <= side_d;
    end
  end

  assign rsp_o.valid = side_q[ST_OUT].valid;
  assign rsp_o.out_i = out_q[0];
  assign rsp_o.out_j = out_q[1];
  assign rsp_o.out_k = out_q[2];
  assign rsp_o.out_r = out_q[3];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> side_q[0].valid)
    else $error("accepted item did not enter the first stage");

  a_divisor_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q[ST_DIV0].valid && side_q[ST_DIV0].kind == KIND_SLERP) |-> (side_q[ST_DIV0].s != '0))
    else $error("spherical item reached the divider with a zero sine");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(side_q[ST_W].valid) && $stable(side_q[ST_SQRT0].valid)))
    else $error("pipeline moved while the output was stalled");

  a_linear_dot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (side_q[ST_RAD].valid && side_q[ST_RAD].kind == KIND_SLERP) |->
    (side_q[ST_RAD].c < C_W'(ONE - 1) || side_q[ST_RAD].c == C_W'(ONE - 1)))
    else $error("spherical item carries a dot product at or above one");

endmodule
